[hdl/http_range_request_resolver_assert.svh]
// Assertion macros shared by the resolver RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef HTTP_RANGE_REQUEST_RESOLVER_ASSERT_SVH
`define HTTP_RANGE_REQUEST_RESOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Condition must hold at every clock edge outside reset.
`define RRR_ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// Antecedent implies consequent in the same cycle.
`define RRR_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");

// Antecedent implies consequent in the next cycle.
`define RRR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");

`else

`define RRR_ASSERT_ALWAYS(label, clk, rst, cond)
`define RRR_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RRR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[hdl/rrr_pkg.sv]
package rrr_pkg;

  localparam int unsigned LEN_W = 64;
  localparam logic [LEN_W-1:0] ALL_ONES = {LEN_W{1'b1}};

  // Prefix "bytes=" length
  localparam logic [2:0] PREFIX_LEN = 3'd6;

  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Verdict codes
  localparam logic [1:0] VERDICT_MALFORMED = 2'd0;
  localparam logic [1:0] VERDICT_WHOLE     = 2'd1;
  localparam logic [1:0] VERDICT_UNSAT     = 2'd2;
  localparam logic [1:0] VERDICT_PARTIAL   = 2'd3;

  typedef enum logic [1:0] {
    PH_PREFIX,
    PH_FIRST,
    PH_LAST
  } phase_t;

  typedef struct packed {
    logic [7:0]       header_char;
    logic             final_char;
    logic [LEN_W-1:0] resource_length;
  } char_item_t;

  typedef struct packed {
    logic [1:0]       verdict;
    logic [LEN_W-1:0] range_begin;
    logic [LEN_W-1:0] range_end;
  } range_result_t;

  // Expected character at each prefix position
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0:    ch = 8'h62; // b
      3'd1:    ch = 8'h79; // y
      3'd2:    ch = 8'h74; // t
      3'd3:    ch = 8'h65; // e
      3'd4:    ch = 8'h73; // s
      3'd5:    ch = 8'h3D; // =
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[hdl/http_range_request_resolver.sv]
// Channel | Direction | Handshake                | Payload
// char    | in        | char_valid / char_ready  | char_item    (rrr_pkg::char_item_t)
// range   | out       | range_valid / range_ready| range_result (rrr_pkg::range_result_t)
//
// One header byte per cycle while no final byte waits on the judge register;
// the parse stage updates the digit accumulators (shift-add by ten) per digit.
// A result travels from the input register holding its final byte: parse
// stage into the judge register, then judge stage into the output register.
// Synchronous reset clears all valids and the parser state; no clearing pass.
// A stalled range channel backs up through the judge register; non-final
// bytes keep flowing as long as the judge register need not be loaded.
`include "http_range_request_resolver_assert.svh"

module http_range_request_resolver (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_ready,
  input  rrr_pkg::char_item_t   char_item,
  output logic                  range_valid,
  input  logic                  range_ready,
  output rrr_pkg::range_result_t range_result
);

  import rrr_pkg::*;

  // Snapshot of the parser at a final byte
  typedef struct packed {
    logic             ok;
    logic             first_seen;
    logic [LEN_W-1:0] first_value;
    logic             last_seen;
    logic [LEN_W-1:0] last_value;
    logic [LEN_W-1:0] resource_length;
  } judge_item_t;

  // Input register
  logic       in_q_valid;
  char_item_t in_q;

  // Parser state
  phase_t           parse_phase, parse_phase_next;
  logic [2:0]       prefix_position, prefix_position_next;
  logic [LEN_W-1:0] first_value, first_value_next;
  logic             first_seen, first_seen_next;
  logic [LEN_W-1:0] last_value, last_value_next;
  logic             last_seen, last_seen_next;
  logic             bad_syntax, bad_syntax_next;

  // Judge register
  logic        judge_valid;
  judge_item_t judge_q;
  judge_item_t judge_next;

  range_result_t result_next;

  logic out_free, judge_free, parse_adv;

  // Flow control
  assign out_free   = !range_valid || range_ready;
  assign judge_free = !judge_valid || out_free;
  assign parse_adv  = in_q_valid && (!in_q.final_char || judge_free);
  assign char_ready = !in_q_valid || parse_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (char_ready) begin
      in_q_valid <= char_valid;
    end
    if (char_ready && char_valid) begin
      in_q <= char_item;
    end
  end

  // Parse one byte
  logic             is_digit;
  logic [3:0]       digit;
  logic [LEN_W-1:0] acc_in;
  logic [LEN_W+3:0] acc_ten;
  logic             acc_ovf;

  assign is_digit = (in_q.header_char >= CHAR_ZERO) && (in_q.header_char <= CHAR_NINE);
  assign digit    = in_q.header_char[3:0];
  assign acc_in   = (parse_phase == PH_LAST) ? last_value : first_value;
  assign acc_ten  = ({4'd0, acc_in} << 3) + ({4'd0, acc_in} << 1) + {{LEN_W{1'b0}}, digit};
  assign acc_ovf  = |acc_ten[LEN_W+3:LEN_W];

  always_comb begin
    parse_phase_next     = parse_phase;
    prefix_position_next = prefix_position;
    first_value_next     = first_value;
    first_seen_next      = first_seen;
    last_value_next      = last_value;
    last_seen_next       = last_seen;
    bad_syntax_next      = bad_syntax;
    if (!bad_syntax) begin
      unique case (parse_phase)
        PH_PREFIX: begin
          if (prefix_position < PREFIX_LEN &&
              in_q.header_char == prefix_char(prefix_position)) begin
            prefix_position_next = prefix_position + 3'd1;
            if (prefix_position_next == PREFIX_LEN) begin
              parse_phase_next = PH_FIRST;
            end
          end else begin
            bad_syntax_next = 1'b1;
          end
        end
        PH_FIRST: begin
          if (is_digit) begin
            if (acc_ovf) begin
              bad_syntax_next = 1'b1;
            end else begin
              first_value_next = acc_ten[LEN_W-1:0];
            end
            first_seen_next = 1'b1;
          end else if (in_q.header_char == CHAR_DASH) begin
            parse_phase_next = PH_LAST;
          end else begin
            bad_syntax_next = 1'b1;
          end
        end
        PH_LAST: begin
          if (is_digit) begin
            if (acc_ovf) begin
              bad_syntax_next = 1'b1;
            end else begin
              last_value_next = acc_ten[LEN_W-1:0];
            end
            last_seen_next = 1'b1;
          end else begin
            bad_syntax_next = 1'b1;
          end
        end
        default: bad_syntax_next = 1'b1;
      endcase
    end

    judge_next.ok = !bad_syntax_next && (parse_phase_next == PH_LAST) &&
                    (first_seen_next || last_seen_next);
    judge_next.first_seen      = first_seen_next;
    judge_next.first_value     = first_value_next;
    judge_next.last_seen       = last_seen_next;
    judge_next.last_value      = last_value_next;
    judge_next.resource_length = in_q.resource_length;
  end

  // Parser state register; a final byte returns it to reset values
  always_ff @(posedge clk) begin
    if (rst || (parse_adv && in_q.final_char)) begin
      parse_phase     <= PH_PREFIX;
      prefix_position <= 3'd0;
      first_value     <= '0;
      first_seen      <= 1'b0;
      last_value      <= '0;
      last_seen       <= 1'b0;
      bad_syntax      <= 1'b0;
    end else if (parse_adv) begin
      parse_phase     <= parse_phase_next;
      prefix_position <= prefix_position_next;
      first_value     <= first_value_next;
      first_seen      <= first_seen_next;
      last_value      <= last_value_next;
      last_seen       <= last_seen_next;
      bad_syntax      <= bad_syntax_next;
    end
  end

  // Judge register
  always_ff @(posedge clk) begin
    if (rst) begin
      judge_valid <= 1'b0;
    end else if (judge_free) begin
      judge_valid <= parse_adv && in_q.final_char;
    end
    if (judge_free && parse_adv && in_q.final_char) begin
      judge_q <= judge_next;
    end
  end

  // Verdict against the resource length
  logic [LEN_W-1:0] f_val, l_val, len;
  logic             f_absent;
  logic [LEN_W:0]   l_plus_one;

  assign len        = judge_q.resource_length;
  assign f_val      = judge_q.first_seen ? judge_q.first_value : ALL_ONES;
  assign l_val      = judge_q.last_seen ? judge_q.last_value : ALL_ONES;
  assign f_absent   = (f_val == ALL_ONES);
  assign l_plus_one = {1'b0, l_val} + {{LEN_W{1'b0}}, 1'b1};

  always_comb begin
    result_next.verdict     = VERDICT_MALFORMED;
    result_next.range_begin = '0;
    result_next.range_end   = '0;
    if (!judge_q.ok) begin
      result_next.verdict = VERDICT_MALFORMED;
    end else if (!f_absent && f_val > l_val) begin
      result_next.verdict = VERDICT_MALFORMED;
    end else if (len == '0) begin
      result_next.verdict = VERDICT_UNSAT;
    end else if (f_absent) begin
      // Suffix range
      if (l_val == '0) begin
        result_next.verdict = VERDICT_UNSAT;
      end else if (l_val >= len) begin
        result_next.verdict = VERDICT_WHOLE;
      end else begin
        result_next.verdict     = VERDICT_PARTIAL;
        result_next.range_begin = len - l_val;
        result_next.range_end   = len;
      end
    end else if (f_val >= len) begin
      result_next.verdict = VERDICT_UNSAT;
    end else if (l_plus_one >= {1'b0, len}) begin
      // Last position reaches the end: clip
      if (f_val == '0) begin
        result_next.verdict = VERDICT_WHOLE;
      end else begin
        result_next.verdict     = VERDICT_PARTIAL;
        result_next.range_begin = f_val;
        result_next.range_end   = len;
      end
    end else begin
      result_next.verdict     = VERDICT_PARTIAL;
      result_next.range_begin = f_val;
      result_next.range_end   = l_plus_one[LEN_W-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      range_valid <= 1'b0;
    end else if (out_free) begin
      range_valid <= judge_valid;
    end
    if (out_free && judge_valid) begin
      range_result <= result_next;
    end
  end

  // Assertions
  `RRR_ASSERT_IMPLY(a_nonpartial_zero, clk, rst,
    range_valid && range_result.verdict != VERDICT_PARTIAL,
    range_result.range_begin == '0 && range_result.range_end == '0)
  `RRR_ASSERT_IMPLY(a_partial_nonempty, clk, rst,
    range_valid && range_result.verdict == VERDICT_PARTIAL,
    range_result.range_begin < range_result.range_end)
  `RRR_ASSERT_ALWAYS(a_prefix_done, clk, rst,
    parse_phase == PH_PREFIX || prefix_position == PREFIX_LEN)
  `RRR_ASSERT_NEXT(a_final_clears, clk, rst,
    parse_adv && in_q.final_char,
    parse_phase == PH_PREFIX && prefix_position == 3'd0 && !bad_syntax)

endmodule
